[rtl/core/keypad_event_modifier_decoder_unit_macros.svh]
`ifndef KEYPAD_EVENT_MODIFIER_DECODER_UNIT_MACROS_SVH
`define KEYPAD_EVENT_MODIFIER_DECODER_UNIT_MACROS_SVH

// check a property outside reset
`define KEMD_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define KEMD_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/kemd_pkg.sv]
package kemd_pkg;

    localparam int ENC_WIDTH = 10;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 4;
    localparam int IDX_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 8;

    localparam logic [7:0] KEY_ABSENT = 8'hFF;
    localparam logic [7:0] RECIP_10   = 8'd205;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        MAP_LOWER  = 2'd0,
        MAP_UPPER  = 2'd1,
        MAP_SYMBOL = 2'd2,
        MAP_NONE   = 2'd3
    } t_map;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_COUNT   = 3'd0,
        CFG_MIRROR_COLUMNS = 3'd1,
        CFG_SHIFT_KEY_ROW  = 3'd2,
        CFG_SHIFT_KEY_COL  = 3'd3,
        CFG_SYMBOL_KEY_ROW = 3'd4,
        CFG_SYMBOL_KEY_COL = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [3:0] column_count;
        logic       mirror_columns;
        logic [7:0] shift_key_row;
        logic [7:0] shift_key_col;
        logic [7:0] symbol_key_row;
        logic [7:0] symbol_key_col;
    } t_cfg;

    // code / 10 for any 8-bit code
    function automatic logic [ROW_W-1:0] row_of(input logic [7:0] code);
        logic [15:0] prod;
        prod = {8'd0, code} * {8'd0, RECIP_10};
        return prod[15:11];
    endfunction

endpackage

[rtl/core/keypad_event_modifier_decoder_unit.sv]
// channel | direction | handshake                  | word
// in      | sink      | i_in_valid / o_in_ready    | kind, event, table write fields
// out     | source    | o_out_valid / i_out_ready  | key_char, pressed, last
// cfg     | sink      | i_cfg_valid / o_cfg_ready  | register index, data
//
// A key press that finds a character gives two words, a press and then a release; the output
// register and the single keymap read port hold the next lookup until the release word is loaded.
// Other events and keymap writes leave the lookup stage without waiting for the read port.
// The press word passes the lookup register, the keymap read register and the output register.
// After reset all 3 * KEYMAP_DEPTH keymap entries are cleared; o_in_ready stays low then.
// A stalled output holds the lookup stage, which in turn holds the input.
module keypad_event_modifier_decoder_unit import kemd_pkg::*; #(
    parameter int KEYMAP_DEPTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [7:0]           i_event_byte,
    input  logic [1:0]           i_table_select,
    input  logic [6:0]           i_table_index,
    input  logic [7:0]           i_table_char,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_key_char,
    output logic                 o_pressed,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int AW = $clog2(3 * KEYMAP_DEPTH);

    t_cfg r_cfg;

    logic              wr_en, rd_en, busy, s2_free;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_count   <= 4'd10;
            r_cfg.mirror_columns <= 1'b0;
            r_cfg.shift_key_row  <= KEY_ABSENT;
            r_cfg.shift_key_col  <= KEY_ABSENT;
            r_cfg.symbol_key_row <= KEY_ABSENT;
            r_cfg.symbol_key_col <= KEY_ABSENT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_COLUMN_COUNT:   r_cfg.column_count   <= i_cfg_data[3:0];
                CFG_MIRROR_COLUMNS: r_cfg.mirror_columns <= i_cfg_data[0];
                CFG_SHIFT_KEY_ROW:  r_cfg.shift_key_row  <= i_cfg_data;
                CFG_SHIFT_KEY_COL:  r_cfg.shift_key_col  <= i_cfg_data;
                CFG_SYMBOL_KEY_ROW: r_cfg.symbol_key_row <= i_cfg_data;
                CFG_SYMBOL_KEY_COL: r_cfg.symbol_key_col <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kemd_decode #(
        .KEYMAP_DEPTH(KEYMAP_DEPTH)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_event_byte   (i_event_byte),
        .i_table_select (i_table_select),
        .i_table_index  (i_table_index),
        .i_table_char   (i_table_char),
        .i_cfg          (r_cfg),
        .i_busy         (busy),
        .i_s2_free      (s2_free),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr)
    );

    kemd_keymap #(
        .KEYMAP_DEPTH(KEYMAP_DEPTH)
    ) u_keymap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_busy    (busy)
    );

    kemd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (rd_en),
        .i_rd_data   (rd_data),
        .o_s2_free   (s2_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key_char  (o_key_char),
        .o_pressed   (o_pressed),
        .o_last      (o_last)
    );

endmodule

[rtl/core/kemd_keymap.sv]
module kemd_keymap import kemd_pkg::*; #(
    parameter int KEYMAP_DEPTH = 128,
    localparam int ENTRIES = 3 * KEYMAP_DEPTH,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    output logic              o_busy
);

    logic [DATA_W-1:0] r_mem [ENTRIES];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

[rtl/core/kemd_decode.sv]
module kemd_decode import kemd_pkg::*; #(
    parameter int KEYMAP_DEPTH = 128,
    localparam int AW = $clog2(3 * KEYMAP_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_event_byte,
    input  logic [1:0]        i_table_select,
    input  logic [6:0]        i_table_index,
    input  logic [7:0]        i_table_char,
    input  t_cfg              i_cfg,
    input  logic              i_busy,
    input  logic              i_s2_free,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr
);

    logic             r_s1_valid;
    t_kind            r_s1_kind;
    logic             r_s1_evnz;
    logic             r_s1_down;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    logic [1:0]       r_s1_sel;
    logic [6:0]       r_s1_index;
    logic [7:0]       r_s1_char;

    logic r_shift_held, r_symbol_held, r_caps_on, r_caps_armed;
    logic n_shift_held, n_symbol_held, n_caps_on, n_caps_armed;

    logic             accept;
    logic [7:0]       in_code;
    logic [ROW_W-1:0] in_row;
    logic [7:0]       in_rem;

    logic [7:0]       vcol;
    logic [7:0]       row8;
    logic             shift_hit, is_sym, is_event, needs_lookup, s1_fire;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    t_map             lookup_map;
    logic [AW-1:0]    rd_base, wr_base;

    assign in_code = {1'b0, i_event_byte[6:0]} - 8'd1;
    assign in_row  = row_of(in_code);
    assign in_rem  = in_code - {in_row, 3'b000} - {2'b00, in_row, 1'b0};

    assign row8 = 8'(r_s1_row);
    assign vcol = i_cfg.mirror_columns
        ? ({4'd0, i_cfg.column_count} - 8'd1 - {4'd0, r_s1_col})
        : {4'd0, r_s1_col};

    assign shift_hit = (row8 == i_cfg.shift_key_row) && (vcol == i_cfg.shift_key_col);
    assign is_sym    = (row8 == i_cfg.symbol_key_row) && (vcol == i_cfg.symbol_key_col);
    assign is_event  = r_s1_valid && (r_s1_kind == KIND_EVENT) && r_s1_evnz;

    assign idx = IDX_W'(r_s1_row) * IDX_W'(i_cfg.column_count) + IDX_W'(vcol);
    assign in_range = 32'(idx) < 32'(KEYMAP_DEPTH);

    always_comb begin
        priority if (r_symbol_held) begin
            lookup_map = MAP_SYMBOL;
        end else if (r_shift_held || r_caps_on) begin
            lookup_map = MAP_UPPER;
        end else begin
            lookup_map = MAP_LOWER;
        end
    end

    always_comb begin
        unique case (lookup_map)
            MAP_UPPER:  rd_base = AW'(KEYMAP_DEPTH);
            MAP_SYMBOL: rd_base = AW'(2 * KEYMAP_DEPTH);
            default:    rd_base = '0;
        endcase
    end

    always_comb begin
        unique case (t_map'(r_s1_sel))
            MAP_LOWER:  wr_base = '0;
            MAP_UPPER:  wr_base = AW'(KEYMAP_DEPTH);
            MAP_SYMBOL: wr_base = AW'(2 * KEYMAP_DEPTH);
            default:    wr_base = '0;
        endcase
    end

    assign needs_lookup = is_event && r_s1_down && !shift_hit && !is_sym && in_range;
    assign s1_fire      = r_s1_valid && (!needs_lookup || i_s2_free);
    assign o_in_ready   = !i_busy && (!r_s1_valid || s1_fire);
    assign accept       = i_in_valid && o_in_ready;

    assign o_rd_en   = needs_lookup && i_s2_free;
    assign o_rd_addr = rd_base + AW'(idx);

    assign o_wr_en = r_s1_valid && (r_s1_kind == KIND_WRITE)
        && (t_map'(r_s1_sel) != MAP_NONE) && (32'(r_s1_index) < 32'(KEYMAP_DEPTH));
    assign o_wr_addr = wr_base + AW'(r_s1_index);
    assign o_wr_data = r_s1_char;

    always_comb begin
        n_shift_held  = r_shift_held;
        n_symbol_held = r_symbol_held;
        n_caps_on     = r_caps_on;
        n_caps_armed  = r_caps_armed;
        if (is_event) begin
            if (!r_s1_down) begin
                if (shift_hit) begin
                    n_shift_held = 1'b0;
                end
                if (is_sym) begin
                    n_symbol_held = 1'b0;
                end
            end else begin
                if (shift_hit) begin
                    n_shift_held = 1'b1;
                end else if (is_sym) begin
                    n_symbol_held = 1'b1;
                end
                if (n_symbol_held && n_shift_held && r_caps_armed
                        && (i_cfg.symbol_key_row != KEY_ABSENT)
                        && (i_cfg.shift_key_row != KEY_ABSENT)) begin
                    n_caps_on    = !r_caps_on;
                    n_caps_armed = 1'b0;
                end
            end
            if (!n_symbol_held && !n_shift_held) begin
                n_caps_armed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_shift_held  <= 1'b0;
            r_symbol_held <= 1'b0;
            r_caps_on     <= 1'b0;
            r_caps_armed  <= 1'b1;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_shift_held  <= n_shift_held;
                r_symbol_held <= n_symbol_held;
                r_caps_on     <= n_caps_on;
                r_caps_armed  <= n_caps_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= t_kind'(i_kind);
            r_s1_evnz  <= i_event_byte != 8'd0;
            r_s1_down  <= i_event_byte[7];
            r_s1_row   <= in_row;
            r_s1_col   <= in_rem[COL_W-1:0];
            r_s1_sel   <= i_table_select;
            r_s1_index <= i_table_index;
            r_s1_char  <= i_table_char;
        end
    end

endmodule

[rtl/core/kemd_emit.sv]
module kemd_emit import kemd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_issue,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic              o_s2_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_key_char,
    output logic              o_pressed,
    output logic              o_last
);

    typedef enum logic {
        PH_PRESS,
        PH_RELEASE
    } t_phase;

    t_phase     r_phase;
    logic       r_s2_valid;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_pressed;
    logic       r_out_last;

    logic out_load, has_char, s2_done;

    assign out_load  = !r_out_valid || i_out_ready;
    assign has_char  = i_rd_data != '0;
    assign s2_done   = r_s2_valid && (!has_char || (out_load && r_phase == PH_RELEASE));
    assign o_s2_free = !r_s2_valid || s2_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PRESS;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_s2_valid && has_char && out_load) begin
                r_out_valid   <= 1'b1;
                r_out_char    <= i_rd_data;
                r_out_pressed <= r_phase == PH_PRESS;
                r_out_last    <= r_phase == PH_RELEASE;
                r_phase       <= (r_phase == PH_PRESS) ? PH_RELEASE : PH_PRESS;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_issue) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_char  = r_out_char;
    assign o_pressed   = r_out_pressed;
    assign o_last      = r_out_last;

endmodule

[rtl/core/kemd_checker.sv]
`include "keypad_event_modifier_decoder_unit_macros.svh"

module kemd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_key_char,
    input logic       o_pressed,
    input logic       o_last
);

    `KEMD_ASSERT_ALL(a_idle_after_reset, i_clk, !i_rst_n |=> !o_out_valid, "output word after reset")

    `KEMD_ASSERT_RST(a_hold_stalled, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_char) && $stable(o_pressed) && $stable(o_last), "stalled word changed")

    `KEMD_ASSERT_RST(a_release_follows, i_clk, i_rst_n, o_out_valid && i_out_ready && o_pressed |=> o_out_valid && !o_pressed && o_last && o_key_char == $past(o_key_char), "release word missing after press")

    `KEMD_ASSERT_RST(a_word_shape, i_clk, i_rst_n, o_out_valid |-> o_key_char != 8'd0 && o_pressed != o_last, "malformed output word")

endmodule

bind keypad_event_modifier_decoder_unit kemd_checker u_kemd_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import kemd_pkg::*;

    localparam int KEYMAP_DEPTH  = 128;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        t_kind      kind;
        logic [7:0] event_byte;
        logic [1:0] table_select;
        logic [6:0] table_index;
        logic [7:0] table_char;
    } t_in_word;

    typedef struct {
        logic [7:0] key_char;
        logic       pressed;
        logic       last;
    } t_key_word;

    typedef struct {
        t_cfg_index index;
        logic [7:0] data;
    } t_reg_write;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic                 i_kind         = 1'b0;
    logic [7:0]           i_event_byte   = '0;
    logic [1:0]           i_table_select = '0;
    logic [6:0]           i_table_index  = '0;
    logic [7:0]           i_table_char   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [7:0]           o_key_char;
    logic                 o_pressed;
    logic                 o_last;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [7:0]           i_cfg_data     = '0;

    t_cfg       cfg_model;
    logic [7:0] keymap_model [3][KEYMAP_DEPTH];
    logic       shift_down;
    logic       symbol_down;
    logic       caps_lock;
    logic       caps_ready;

    t_in_word   in_words_pending[$];
    t_key_word  key_words_due[$];
    t_reg_write reg_writes_pending[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         fail_count     = 0;

    keypad_event_modifier_decoder_unit #(
        .KEYMAP_DEPTH(KEYMAP_DEPTH)
    ) u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic decode_key_word(input t_in_word w);
        logic [7:0]  code;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  vcol;
        logic [7:0]  found;
        logic        on_shift;
        logic        on_symbol;
        int unsigned slot;
        t_map        pick;
        if (w.kind == KIND_WRITE) begin
            if (w.table_select != MAP_NONE && int'(w.table_index) < KEYMAP_DEPTH) begin
                keymap_model[w.table_select][w.table_index] = w.table_char;
            end
            return;
        end
        if (w.event_byte == 8'd0) begin
            return;
        end
        code = {1'b0, w.event_byte[6:0]} - 8'd1;
        row  = 8'(code / ENC_WIDTH);
        col  = 8'(code % ENC_WIDTH);
        vcol = cfg_model.mirror_columns ? {4'd0, cfg_model.column_count} - 8'd1 - col : col;
        on_shift  = row == cfg_model.shift_key_row && vcol == cfg_model.shift_key_col;
        on_symbol = row == cfg_model.symbol_key_row && vcol == cfg_model.symbol_key_col;
        if (!w.event_byte[7]) begin
            if (on_shift) begin
                shift_down = 1'b0;
            end
            if (on_symbol) begin
                symbol_down = 1'b0;
            end
        end else begin
            if (on_shift) begin
                shift_down = 1'b1;
            end else if (on_symbol) begin
                symbol_down = 1'b1;
            end else begin
                if (symbol_down) begin
                    pick = MAP_SYMBOL;
                end else if (shift_down || caps_lock) begin
                    pick = MAP_UPPER;
                end else begin
                    pick = MAP_LOWER;
                end
                slot  = int'(row) * int'(cfg_model.column_count) + int'(vcol);
                found = (slot < KEYMAP_DEPTH) ? keymap_model[pick][slot[6:0]] : 8'd0;
                if (found != 8'd0) begin
                    key_words_due.push_back(t_key_word'{found, 1'b1, 1'b0});
                    key_words_due.push_back(t_key_word'{found, 1'b0, 1'b1});
                end
            end
            if (shift_down && symbol_down && caps_ready
                    && cfg_model.symbol_key_row != KEY_ABSENT
                    && cfg_model.shift_key_row != KEY_ABSENT) begin
                caps_lock  = !caps_lock;
                caps_ready = 1'b0;
            end
        end
        if (!shift_down && !symbol_down) begin
            caps_ready = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : drive_in
        t_in_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_key_word(t_in_word'{t_kind'(i_kind), i_event_byte, i_table_select,
                                           i_table_index, i_table_char});
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_words_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = in_words_pending.pop_front();
                    i_kind         <= w.kind;
                    i_event_byte   <= w.event_byte;
                    i_table_select <= w.table_select;
                    i_table_index  <= w.table_index;
                    i_table_char   <= w.table_char;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_cfg
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_COLUMN_COUNT:   cfg_model.column_count   = i_cfg_data[3:0];
                    CFG_MIRROR_COLUMNS: cfg_model.mirror_columns = i_cfg_data[0];
                    CFG_SHIFT_KEY_ROW:  cfg_model.shift_key_row  = i_cfg_data;
                    CFG_SHIFT_KEY_COL:  cfg_model.shift_key_col  = i_cfg_data;
                    CFG_SYMBOL_KEY_ROW: cfg_model.symbol_key_row = i_cfg_data;
                    CFG_SYMBOL_KEY_COL: cfg_model.symbol_key_col = i_cfg_data;
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_writes_pending.size() > 0) begin
                    w = reg_writes_pending.pop_front();
                    i_cfg_index <= w.index;
                    i_cfg_data  <= w.data;
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        t_key_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (key_words_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected key word: char %02h pressed %0b last %0b",
                                 o_key_char, o_pressed, o_last);
                    end
                end else begin
                    want = key_words_due.pop_front();
                    if (o_key_char !== want.key_char || o_pressed !== want.pressed
                            || o_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("key word mismatch: expected char %02h pressed %0b last %0b",
                                     want.key_char, want.pressed, want.last);
                            $display("                   got      char %02h pressed %0b last %0b",
                                     o_key_char, o_pressed, o_last);
                        end
                    end
                end
            end
            i_out_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    task automatic push_write(input logic [1:0] sel, input logic [6:0] idx,
                              input logic [7:0] chr);
        in_words_pending.push_back(t_in_word'{KIND_WRITE, 8'($urandom), sel, idx, chr});
    endtask

    task automatic push_event(input logic [7:0] ev);
        in_words_pending.push_back(t_in_word'{KIND_EVENT, ev, 2'($urandom), 7'($urandom),
                                              8'($urandom)});
    endtask

    task automatic push_key(input logic [7:0] code, input logic down);
        push_event({down, 7'(code + 8'd1)});
    endtask

    function automatic logic [7:0] key_col(input logic [3:0] columns, input logic mirror,
                                           input logic [7:0] code);
        logic [7:0] col;
        col = 8'(code % ENC_WIDTH);
        return mirror ? {4'd0, columns} - 8'd1 - col : col;
    endfunction

    task automatic wait_idle();
        while (in_words_pending.size() > 0 || i_in_valid || key_words_due.size() > 0
                || reg_writes_pending.size() > 0 || i_cfg_valid) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] columns, input logic mirror,
                              input logic [7:0] sh_row, input logic [7:0] sh_col,
                              input logic [7:0] sym_row, input logic [7:0] sym_col);
        wait_idle();
        reg_writes_pending.push_back(t_reg_write'{CFG_COLUMN_COUNT, {4'd0, columns}});
        reg_writes_pending.push_back(t_reg_write'{CFG_MIRROR_COLUMNS, {7'd0, mirror}});
        reg_writes_pending.push_back(t_reg_write'{CFG_SHIFT_KEY_ROW, sh_row});
        reg_writes_pending.push_back(t_reg_write'{CFG_SHIFT_KEY_COL, sh_col});
        reg_writes_pending.push_back(t_reg_write'{CFG_SYMBOL_KEY_ROW, sym_row});
        reg_writes_pending.push_back(t_reg_write'{CFG_SYMBOL_KEY_COL, sym_col});
        wait_idle();
    endtask

    task automatic random_key_words(input int n, input logic [7:0] shift_code,
                                    input logic [7:0] sym_code);
        int         pick;
        logic [7:0] code;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                push_write(2'($urandom), 7'($urandom),
                           ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom));
            end else if (pick < 32) begin
                code = $urandom_range(1) ? shift_code : sym_code;
                push_key(code, 1'($urandom));
            end else if (pick < 42) begin
                if ($urandom_range(7) == 0) begin
                    push_event(8'd0);
                end else if ($urandom_range(1)) begin
                    push_event(8'($urandom));
                end else begin
                    push_write(2'($urandom), 7'($urandom), 8'($urandom));
                    in_words_pending[$].kind = t_kind'($urandom_range(1));
                end
            end else begin
                code = 8'($urandom_range(126));
                push_key(code, 1'b1);
                push_key(code, 1'b0);
            end
        end
    endtask

    task automatic run_phase(input logic [3:0] columns, input logic mirror, input logic mods,
                             input logic [7:0] shift_code, input logic [7:0] sym_code,
                             input int n, input int idle_pct, input int stall_pct);
        if (mods) begin
            set_config(columns, mirror,
                       8'(shift_code / ENC_WIDTH), key_col(columns, mirror, shift_code),
                       8'(sym_code / ENC_WIDTH), key_col(columns, mirror, sym_code));
        end else begin
            set_config(columns, mirror, KEY_ABSENT, 8'($urandom), KEY_ABSENT, 8'($urandom));
        end
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        random_key_words(n, shift_code, sym_code);
    endtask

    initial begin
        cfg_model = '{column_count: 4'd10, mirror_columns: 1'b0,
                      shift_key_row: KEY_ABSENT, shift_key_col: 8'hFF,
                      symbol_key_row: KEY_ABSENT, symbol_key_col: 8'hFF};
        foreach (keymap_model[m, k]) keymap_model[m][k] = 8'd0;
        shift_down  = 1'b0;
        symbol_down = 1'b0;
        caps_lock   = 1'b0;
        caps_ready  = 1'b1;

        // reset settings, no modifier keys
        push_write(MAP_LOWER, 7'd0, 8'hFF);
        push_write(MAP_UPPER, 7'd127, 8'h01);
        push_write(MAP_NONE, 7'd1, 8'h55);
        push_write(MAP_LOWER, 7'd126, 8'h80);
        push_event(8'h00);
        push_key(8'd0, 1'b1);
        push_key(8'd0, 1'b0);
        push_key(8'd1, 1'b1);
        push_event(8'hFF);
        push_event(8'h80);
        push_event(8'h7F);
        push_key(8'd2, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // shift at row 2 col 0, symbol at row 2 col 1: walk caps lock on and off
        set_config(4'd10, 1'b0, 8'd2, 8'd0, 8'd2, 8'd1);
        push_write(MAP_LOWER, 7'd5, 8'h61);
        push_write(MAP_UPPER, 7'd5, 8'h41);
        push_write(MAP_SYMBOL, 7'd5, 8'h25);
        push_key(8'd20, 1'b1);
        push_key(8'd21, 1'b1);
        push_key(8'd5, 1'b1);
        push_key(8'd21, 1'b0);
        push_key(8'd5, 1'b1);
        push_key(8'd20, 1'b0);
        push_key(8'd5, 1'b1);
        push_key(8'd21, 1'b1);
        push_key(8'd20, 1'b1);
        push_key(8'd20, 1'b0);
        push_key(8'd21, 1'b0);
        push_key(8'd5, 1'b1);
        push_key(8'd5, 1'b0);

        // load all three keymaps, a few entries left blank
        for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < KEYMAP_DEPTH; k++) begin
                push_write(2'(m), 7'(k),
                           ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
            end
        end

        run_phase(4'd10, 1'b0, 1'b1, 8'd20, 8'd21, 130, 0, 0);
        run_phase(4'd7, 1'b1, 1'b1, 8'd0, 8'd126, 130, 60, 0);
        run_phase(4'd1, 1'b0, 1'b1, 8'd33, 8'd47, 70, 0, 60);
        // wait until every pending word is sent and every expected key word is seen
        wait_idle();
        random_key_words(70, 8'd33, 8'd47);
        run_phase(4'd0, 1'b0, 1'b0, 8'd0, 8'd0, 70, 15, 15);
        run_phase(4'd10, 1'b1, 1'b1, 8'd9, 8'd90, 130, 15, 15);
        run_phase(4'd4, 1'b0, 1'b1, 8'd3, 8'd12, 100, 0, 0);

        wait_idle();
        repeat (12) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/kemd_pkg.sv
rtl/core/kemd_keymap.sv
rtl/core/kemd_decode.sv
rtl/core/kemd_emit.sv
rtl/core/keypad_event_modifier_decoder_unit.sv
rtl/core/kemd_checker.sv
dv/testbench.sv
